/* rtl/fea_pkg.sv */
package fea_pkg;

   localparam int LIMB_W   = 51;
   localparam int IN_W     = 54;
   localparam int OUT_W    = 64;
   localparam int Y19_W    = 59;
   localparam int PROD_W   = 113;
   localparam int COL_W    = 117;
   localparam int CARRY_HI = LIMB_W + OUT_W - 1;
   localparam int PIPE_DEPTH = 8;

   localparam logic [OUT_W-1:0] LIMB_MASK = 64'h0007_FFFF_FFFF_FFFF;
   localparam logic [OUT_W-1:0] TWO_P0    = 64'h000F_FFFF_FFFF_FFDA;
   localparam logic [OUT_W-1:0] TWO_P1    = 64'h000F_FFFF_FFFF_FFFE;
   localparam logic [OUT_W-1:0] P0_LIMB   = LIMB_MASK - 64'd18;
   localparam logic [OUT_W-1:0] K19       = 64'd19;
   localparam logic [16:0]      K121666   = 17'd121666;

   typedef enum logic [3:0] {
      FN_ADD       = 4'd0,
      FN_SUB       = 4'd1,
      FN_NEG       = 4'd2,
      FN_MUL       = 4'd3,
      FN_SQR       = 4'd4,
      FN_MUL121666 = 4'd5,
      FN_CARRY     = 4'd6,
      FN_REDUCE    = 4'd7,
      FN_CMOV      = 4'd8,
      FN_ISZERO    = 4'd9,
      FN_ISNEG     = 4'd10,
      FN_EQ        = 4'd11
   } func_type;

   typedef logic [4:0][IN_W-1:0]  in_vec_type;
   typedef logic [4:0][Y19_W-1:0] y19_vec_type;
   typedef logic [4:0][OUT_W-1:0] out_vec_type;
   typedef logic [4:0][COL_W-1:0] col_vec_type;

endpackage

/* rtl/fea_req_if.sv */
interface fea_req_if;
   logic                     valid;
   logic                     ready;
   logic [3:0]               func;
   logic [fea_pkg::IN_W-1:0] a_limb0;
   logic [fea_pkg::IN_W-1:0] a_limb1;
   logic [fea_pkg::IN_W-1:0] a_limb2;
   logic [fea_pkg::IN_W-1:0] a_limb3;
   logic [fea_pkg::IN_W-1:0] a_limb4;
   logic [fea_pkg::IN_W-1:0] b_limb0;
   logic [fea_pkg::IN_W-1:0] b_limb1;
   logic [fea_pkg::IN_W-1:0] b_limb2;
   logic [fea_pkg::IN_W-1:0] b_limb3;
   logic [fea_pkg::IN_W-1:0] b_limb4;
   logic                     cond;

   modport source (output valid, func, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
                   b_limb0, b_limb1, b_limb2, b_limb3, b_limb4, cond, input ready);
   modport sink (input valid, func, a_limb0, a_limb1, a_limb2, a_limb3, a_limb4,
                 b_limb0, b_limb1, b_limb2, b_limb3, b_limb4, cond, output ready);
endinterface

/* rtl/fea_rsp_if.sv */
interface fea_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fea_pkg::OUT_W-1:0] r_limb0;
   logic [fea_pkg::OUT_W-1:0] r_limb1;
   logic [fea_pkg::OUT_W-1:0] r_limb2;
   logic [fea_pkg::OUT_W-1:0] r_limb3;
   logic [fea_pkg::OUT_W-1:0] r_limb4;
   logic                      flag;

   modport source (output valid, r_limb0, r_limb1, r_limb2, r_limb3, r_limb4, flag,
                   input ready);
   modport sink (input valid, r_limb0, r_limb1, r_limb2, r_limb3, r_limb4, flag,
                 output ready);
endinterface

/* rtl/field_element_alu.sv */
// Channel   Direction  Contents
// req_chan  in         func, a_limb0..a_limb4, b_limb0..b_limb4, cond
// rsp_chan  out        r_limb0..r_limb4, flag
//
// Every request passes from acceptance to its response through one input stage,
// eight pipeline stages (three in the 25-product multiplier, five in the carry fold)
// and the output register. A new request may enter every cycle the pipeline advances.
// Reset clears only the valid bits; the data registers carry no reset.
// When a response waits at the output and is not taken, the whole pipeline holds.
module field_element_alu (
   input logic       clock,
   input logic       reset,
   fea_req_if.sink   req_chan,
   fea_rsp_if.source rsp_chan
);
   import fea_pkg::*;

   // The pipeline advances whenever the output register is free or being emptied.
   logic en;

   in_vec_type  a_raw, b_raw, y_raw;
   y19_vec_type y19_in;

   func_type    func_s1_ff;
   in_vec_type  a_s1_ff, b_s1_ff, y_mul;
   y19_vec_type y19_s1_ff;
   logic        cond_s1_ff;

   logic [PIPE_DEPTH:0] vld_ff;
   func_type            fn_ff [1:PIPE_DEPTH];

   col_vec_type col;
   out_vec_type fold_r, lin_r;
   logic        lin_flag;

   out_vec_type rsp_r_in, rsp_r_ff;
   logic        rsp_flag_in, rsp_flag_ff;
   logic        rsp_vld_ff;

   assign en             = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   assign a_raw = {req_chan.a_limb4, req_chan.a_limb3, req_chan.a_limb2,
                   req_chan.a_limb1, req_chan.a_limb0};
   assign b_raw = {req_chan.b_limb4, req_chan.b_limb3, req_chan.b_limb2,
                   req_chan.b_limb1, req_chan.b_limb0};

   // Squaring is a multiply of the first operand by itself. The times-19 copies of
   // the second factor are formed by shifts and adds before the input register.
   always_comb begin
      y_raw = (func_type'(req_chan.func) == FN_SQR) ? a_raw : b_raw;
      for (int j = 0; j < 5; j++) begin
         y19_in[j] = (Y19_W'(y_raw[j]) << 4) + (Y19_W'(y_raw[j]) << 1) + Y19_W'(y_raw[j]);
      end
   end

   assign y_mul = (func_s1_ff == FN_SQR) ? a_s1_ff : b_s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-1:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func_s1_ff <= func_type'(req_chan.func);
         a_s1_ff    <= a_raw;
         b_s1_ff    <= b_raw;
         y19_s1_ff  <= y19_in;
         cond_s1_ff <= req_chan.cond;
         fn_ff[1]   <= func_s1_ff;
         for (int k = 2; k <= PIPE_DEPTH; k++) begin
            fn_ff[k] <= fn_ff[k-1];
         end
      end
   end

   fea_mul u_mul (
      .clock (clock),
      .en    (en),
      .x     (a_s1_ff),
      .y     (y_mul),
      .y19   (y19_s1_ff),
      .m121  (func_s1_ff == FN_MUL121666),
      .col   (col)
   );

   // The multiply-by-121666 result keeps its folded top carry in limb 0 unpropagated.
   fea_fold u_fold (
      .clock    (clock),
      .en       (en),
      .col      (col),
      .keep_top (fn_ff[3] == FN_MUL121666),
      .r        (fold_r)
   );

   // Additive, carry, reduction, select and flag operations.
   fea_lin u_lin (
      .clock (clock),
      .en    (en),
      .func  (func_s1_ff),
      .a     (a_s1_ff),
      .b     (b_s1_ff),
      .cond  (cond_s1_ff),
      .r     (lin_r),
      .flag  (lin_flag)
   );

   always_comb begin
      if (fn_ff[PIPE_DEPTH] inside {FN_MUL, FN_SQR, FN_MUL121666}) begin
         rsp_r_in    = fold_r;
         rsp_flag_in = 1'b0;
      end else begin
         rsp_r_in    = lin_r;
         rsp_flag_in = lin_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vld_ff[PIPE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_r_ff    <= rsp_r_in;
         rsp_flag_ff <= rsp_flag_in;
      end
   end

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.r_limb0 = rsp_r_ff[0];
   assign rsp_chan.r_limb1 = rsp_r_ff[1];
   assign rsp_chan.r_limb2 = rsp_r_ff[2];
   assign rsp_chan.r_limb3 = rsp_r_ff[3];
   assign rsp_chan.r_limb4 = rsp_r_ff[4];
   assign rsp_chan.flag    = rsp_flag_ff;

endmodule

/* rtl/fea_mul.sv */
module fea_mul (
   input  logic                 clock,
   input  logic                 en,
   input  fea_pkg::in_vec_type  x,
   input  fea_pkg::in_vec_type  y,
   input  fea_pkg::y19_vec_type y19,
   input  logic                 m121,
   output fea_pkg::col_vec_type col
);
   import fea_pkg::*;

   // Weight of operand limb j in column i.
   logic [4:0][4:0][Y19_W-1:0] w;

   logic [4:0][4:0][56:0] pp_ll_in, pp_ll_ff, pp_hl_in, pp_hl_ff;
   logic [4:0][4:0][55:0] pp_lh_in, pp_lh_ff, pp_hh_in, pp_hh_ff;
   logic [4:0][4:0][PROD_W-1:0] prod_in, prod_ff;
   col_vec_type col_in, col_ff;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 5; j++) begin
            if (m121) begin
               w[i][j] = (i == j) ? Y19_W'(K121666) : '0;
            end else if (j <= i) begin
               w[i][j] = Y19_W'(y[i-j]);
            end else begin
               w[i][j] = y19[i-j+5];
            end
            pp_ll_in[i][j] = x[j][26:0]  * w[i][j][29:0];
            pp_lh_in[i][j] = x[j][26:0]  * w[i][j][58:30];
            pp_hl_in[i][j] = x[j][53:27] * w[i][j][29:0];
            pp_hh_in[i][j] = x[j][53:27] * w[i][j][58:30];
            prod_in[i][j] = PROD_W'(pp_ll_ff[i][j])
                          + (PROD_W'(pp_lh_ff[i][j]) << 30)
                          + (PROD_W'(pp_hl_ff[i][j]) << 27)
                          + (PROD_W'(pp_hh_ff[i][j]) << 57);
         end
      end
      for (int i = 0; i < 5; i++) begin
         col_in[i] = '0;
         for (int j = 0; j < 5; j++) begin
            col_in[i] = col_in[i] + COL_W'(prod_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         prod_ff  <= prod_in;
         col_ff   <= col_in;
      end
   end

   assign col = col_ff;

endmodule

/* rtl/fea_fold.sv */
module fea_fold (
   input  logic                 clock,
   input  logic                 en,
   input  fea_pkg::col_vec_type col,
   input  logic                 keep_top,
   output fea_pkg::out_vec_type r
);
   import fea_pkg::*;

   col_vec_type src [0:3];
   col_vec_type stg_in [0:3];
   col_vec_type stg_ff [0:3];
   logic [3:0]  skip_ff;

   logic [OUT_W-1:0] top_carry, r0_sum;
   out_vec_type      r_in, r_ff;

   always_comb begin
      src[0] = col;
      for (int k = 1; k < 4; k++) begin
         src[k] = stg_ff[k-1];
      end
      // Each stage moves the carry of one column into the next.
      for (int k = 0; k < 4; k++) begin
         stg_in[k]      = src[k];
         stg_in[k][k]   = COL_W'(src[k][k][LIMB_W-1:0]);
         stg_in[k][k+1] = src[k][k+1] + COL_W'(src[k][k][CARRY_HI:LIMB_W]);
      end

      top_carry = stg_ff[3][4][CARRY_HI:LIMB_W];
      r0_sum    = stg_ff[3][0][OUT_W-1:0] + top_carry * K19;
      r_in[2]   = stg_ff[3][2][OUT_W-1:0];
      r_in[3]   = stg_ff[3][3][OUT_W-1:0];
      r_in[4]   = OUT_W'(stg_ff[3][4][LIMB_W-1:0]);
      if (skip_ff[3]) begin
         r_in[0] = r0_sum;
         r_in[1] = stg_ff[3][1][OUT_W-1:0];
      end else begin
         r_in[0] = r0_sum & LIMB_MASK;
         r_in[1] = stg_ff[3][1][OUT_W-1:0] + (r0_sum >> LIMB_W);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         skip_ff <= {skip_ff[2:0], keep_top};
         r_ff    <= r_in;
      end
   end

   assign r = r_ff;

endmodule

/* rtl/fea_lin.sv */
module fea_lin (
   input  logic                 clock,
   input  logic                 en,
   input  fea_pkg::func_type    func,
   input  fea_pkg::in_vec_type  a,
   input  fea_pkg::in_vec_type  b,
   input  logic                 cond,
   output fea_pkg::out_vec_type r,
   output logic                 flag
);
   import fea_pkg::*;

   localparam int RES_DEPTH = PIPE_DEPTH - 4;

   function automatic out_vec_type sub_2p(input out_vec_type f, input out_vec_type g);
      out_vec_type v;
      v[0] = (f[0] + TWO_P0) - g[0];
      for (int i = 1; i < 5; i++) begin
         v[i] = (f[i] + TWO_P1) - g[i];
      end
      return v;
   endfunction

   function automatic out_vec_type weak_carry(input out_vec_type h);
      out_vec_type     v;
      logic [OUT_W-1:0] c;
      v = h;
      for (int i = 0; i < 4; i++) begin
         c      = v[i] >> LIMB_W;
         v[i]   = v[i] & LIMB_MASK;
         v[i+1] = v[i+1] + c;
      end
      c    = v[4] >> LIMB_W;
      v[4] = v[4] & LIMB_MASK;
      v[0] = v[0] + c * K19;
      c    = v[0] >> LIMB_W;
      v[0] = v[0] & LIMB_MASK;
      v[1] = v[1] + c;
      return v;
   endfunction

   out_vec_type ae, be, zero_vec, t;
   out_vec_type h_in [0:3];
   out_vec_type h_ff [0:3];
   func_type    fn_ff [0:3];
   out_vec_type res_in;
   logic        flag_in;
   out_vec_type res_ff [0:RES_DEPTH-1];
   logic [RES_DEPTH-1:0] flag_ff;

   always_comb begin
      zero_vec = '0;
      for (int i = 0; i < 5; i++) begin
         ae[i] = OUT_W'(a[i]);
         be[i] = OUT_W'(b[i]);
      end

      case (func)
         FN_ADD: begin
            for (int i = 0; i < 5; i++) begin
               h_in[0][i] = ae[i] + be[i];
            end
         end
         FN_SUB:  h_in[0] = sub_2p(ae, be);
         FN_NEG:  h_in[0] = sub_2p(zero_vec, ae);
         FN_CMOV: h_in[0] = cond ? be : ae;
         FN_EQ:   h_in[0] = sub_2p(ae, be);
         default: h_in[0] = ae;
      endcase

      h_in[1] = (fn_ff[0] inside {FN_CARRY, FN_REDUCE, FN_ISZERO, FN_ISNEG, FN_EQ})
              ? weak_carry(h_ff[0]) : h_ff[0];
      h_in[2] = (fn_ff[1] inside {FN_REDUCE, FN_ISZERO, FN_ISNEG, FN_EQ})
              ? weak_carry(h_ff[1]) : h_ff[1];

      // Trial subtraction of p with borrows, kept when the top limb is not negative.
      t[0] = h_ff[2][0] - P0_LIMB;
      for (int i = 1; i < 5; i++) begin
         t[i] = h_ff[2][i] - LIMB_MASK;
      end
      for (int i = 0; i < 4; i++) begin
         t[i+1] = t[i+1] + {{LIMB_W{t[i][OUT_W-1]}}, t[i][OUT_W-1:LIMB_W]};
         t[i]   = t[i] & LIMB_MASK;
      end
      if ((fn_ff[2] inside {FN_REDUCE, FN_ISZERO, FN_ISNEG, FN_EQ}) && !t[4][OUT_W-1]) begin
         h_in[3] = t;
      end else begin
         h_in[3] = h_ff[2];
      end

      res_in  = '0;
      flag_in = 1'b0;
      case (fn_ff[3])
         FN_ADD, FN_SUB, FN_NEG, FN_CARRY, FN_REDUCE, FN_CMOV: res_in = h_ff[3];
         FN_ISZERO, FN_EQ: flag_in = (h_ff[3] == '0);
         FN_ISNEG:         flag_in = h_ff[3][0][0];
         default: begin
            res_in  = '0;
            flag_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            h_ff[k] <= h_in[k];
         end
         fn_ff[0] <= func;
         for (int k = 1; k < 4; k++) begin
            fn_ff[k] <= fn_ff[k-1];
         end
         res_ff[0]  <= res_in;
         flag_ff[0] <= flag_in;
         for (int k = 1; k < RES_DEPTH; k++) begin
            res_ff[k]  <= res_ff[k-1];
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   assign r    = res_ff[RES_DEPTH-1];
   assign flag = flag_ff[RES_DEPTH-1];

endmodule
